// ===== rtl/pqp_pkg.sv =====
// ============================================================================
// pqp_pkg: shared types and constants for the quadratic-P positional PID
// Control word layout, sequencer codes, register indexes and the microcode
// program that drives the arithmetic datapath.
// ============================================================================
package pqp_pkg;

    // Fixed field widths
    localparam int GAIN_W     = 24;
    localparam int ILIM_W     = 24;
    localparam int DLIM_W     = 15;
    localparam int DRIVE_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int STEP_W     = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_QUAD_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_LIMIT = 3'd5;

    // Jump conditions
    localparam logic [1:0] JC_NEXT = 2'd0;  // fall through to the next step
    localparam logic [1:0] JC_IN   = 2'd1;  // advance once an item is taken
    localparam logic [1:0] JC_OUT  = 2'd2;  // jump to target once the output slot is free
    localparam logic [1:0] JC_GOTO = 2'd3;  // unconditional jump to target

    // Multiplier operand A selection
    localparam logic [2:0] A_ERR = 3'd0;
    localparam logic [2:0] A_QG  = 3'd1;
    localparam logic [2:0] A_KP  = 3'd2;
    localparam logic [2:0] A_KI  = 3'd3;
    localparam logic [2:0] A_KD  = 3'd4;

    // Multiplier operand B selection
    localparam logic [2:0] B_ERR  = 3'd0;
    localparam logic [2:0] B_E2LO = 3'd1;
    localparam logic [2:0] B_E2HI = 3'd2;
    localparam logic [2:0] B_ESUM = 3'd3;
    localparam logic [2:0] B_DIFF = 3'd4;

    // Magnitude accumulator operations
    localparam logic [1:0] MAG_HOLD   = 2'd0;
    localparam logic [1:0] MAG_LOAD   = 2'd1;
    localparam logic [1:0] MAG_ADD_HI = 2'd2;

    // Term sign sources
    localparam logic [1:0] SG_P = 2'd0;
    localparam logic [1:0] SG_Q = 2'd1;
    localparam logic [1:0] SG_I = 2'd2;
    localparam logic [1:0] SG_D = 2'd3;

    // Drive accumulator operations
    localparam logic [1:0] ACC_HOLD  = 2'd0;
    localparam logic [1:0] ACC_CLEAR = 2'd1;
    localparam logic [1:0] ACC_ADD   = 2'd2;

    // Program step addresses
    localparam logic [STEP_W-1:0] S_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] S_UPD    = 4'd1;
    localparam logic [STEP_W-1:0] S_SQ     = 4'd2;
    localparam logic [STEP_W-1:0] S_PROP   = 4'd3;
    localparam logic [STEP_W-1:0] S_QLO    = 4'd4;
    localparam logic [STEP_W-1:0] S_QHI    = 4'd5;
    localparam logic [STEP_W-1:0] S_INTEG  = 4'd6;
    localparam logic [STEP_W-1:0] S_DERIV  = 4'd7;
    localparam logic [STEP_W-1:0] S_TERM_D = 4'd8;
    localparam logic [STEP_W-1:0] S_SUM    = 4'd9;
    localparam logic [STEP_W-1:0] S_OUT    = 4'd10;

    typedef struct packed {
        logic [1:0]        jmp;
        logic [STEP_W-1:0] target;
        logic              in_rdy;
        logic [2:0]        a_sel;
        logic [2:0]        b_sel;
        logic              upd_en;
        logic              e2_en;
        logic [1:0]        mag_op;
        logic [1:0]        sign_sel;
        logic              term_en;
        logic [1:0]        acc_op;
        logic              out_ld;
    } ctrl_t;

    typedef struct packed {
        logic in_fire;
        logic out_free;
    } seq_stat_t;

    // The program. Products are registered in the multiplier, so each step from
    // S_SQ to S_DERIV consumes the product whose operands the previous step chose.
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t cw;
        cw = '0;
        cw.jmp = JC_NEXT;
        case (step)
            S_IDLE:
            begin
                cw.in_rdy = 1'b1;
                cw.jmp    = JC_IN;
            end
            S_UPD:
            begin
                cw.upd_en = 1'b1;
                cw.a_sel  = A_ERR;
                cw.b_sel  = B_ERR;
            end
            S_SQ:
            begin
                cw.e2_en  = 1'b1;
                cw.a_sel  = A_KP;
                cw.b_sel  = B_ERR;
                cw.acc_op = ACC_CLEAR;
            end
            S_PROP:
            begin
                cw.a_sel    = A_QG;
                cw.b_sel    = B_E2LO;
                cw.mag_op   = MAG_LOAD;
                cw.sign_sel = SG_P;
            end
            S_QLO:
            begin
                cw.a_sel    = A_QG;
                cw.b_sel    = B_E2HI;
                cw.term_en  = 1'b1;
                cw.mag_op   = MAG_LOAD;
                cw.sign_sel = SG_Q;
            end
            S_QHI:
            begin
                cw.a_sel  = A_KI;
                cw.b_sel  = B_ESUM;
                cw.mag_op = MAG_ADD_HI;
                cw.acc_op = ACC_ADD;
            end
            S_INTEG:
            begin
                cw.a_sel    = A_KD;
                cw.b_sel    = B_DIFF;
                cw.term_en  = 1'b1;
                cw.mag_op   = MAG_LOAD;
                cw.sign_sel = SG_I;
            end
            S_DERIV:
            begin
                cw.term_en  = 1'b1;
                cw.mag_op   = MAG_LOAD;
                cw.sign_sel = SG_D;
                cw.acc_op   = ACC_ADD;
            end
            S_TERM_D:
            begin
                cw.term_en = 1'b1;
                cw.acc_op  = ACC_ADD;
            end
            S_SUM:
            begin
                cw.acc_op = ACC_ADD;
            end
            S_OUT:
            begin
                cw.out_ld = 1'b1;
                cw.jmp    = JC_OUT;
                cw.target = S_IDLE;
            end
            default:
            begin
                cw.jmp    = JC_GOTO;
                cw.target = S_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

// ===== rtl/positional_pid_quadratic_p.sv =====
// ============================================================================
// positional_pid_quadratic_p: positional PID with a quadratic P term
// Top level: stream channels, configuration registers, output register,
// microcode sequencer and arithmetic datapath.
// ============================================================================
// Each input item on the s_ channel carries a target and a measured value; the
// block forms the error, updates the clamped integral and the previous error,
// and returns one drive item on the m_ channel:
//   drive = clamp(qg*e*|e| + kp*e + ki*integral + kd*(e - e_prev)),
// every product being floor-scaled by 2^GAIN_FRAC_BITS on its own.
// An item is taken while the sequencer sits in its idle step. The program then
// runs ten steps through one shared registered multiplier, forming six products
// (the quadratic term needs three) and accumulating the terms behind them, and
// takes the next item only once it has returned to its idle step. The result
// sits in an output register, so the next item is worked on while an earlier
// drive waits; on a stall the program holds in its final step until the output
// register has been emptied. Reset clears the gains, the limits, the integral
// and the previous error; an item can be taken as soon as reset is released.
// The user must write configuration only while no item is in flight; the
// block itself does not enforce it.
//
module positional_pid_quadratic_p #(
    parameter int DATA_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input items
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // s_tdata, from bit 0: target_value, measured_value, zero padding
    input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]   s_tdata,
    // Result items
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // m_tdata, from bit 0: drive
    output logic [pqp_pkg::DRIVE_W-1:0]         m_tdata,
    // Configuration writes
    input  logic                                cfg_we,
    input  logic [pqp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pqp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int GW = pqp_pkg::GAIN_W;

    // Configuration registers
    logic signed [GW-1:0]           quad_gain_reg, prop_gain_reg;
    logic signed [GW-1:0]           integ_gain_reg, deriv_gain_reg;
    logic [pqp_pkg::ILIM_W-1:0]     integ_limit_reg;
    logic [pqp_pkg::DLIM_W-1:0]     drive_limit_reg;

    // Output register
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [pqp_pkg::DRIVE_W-1:0]    m_tdata_reg, m_tdata_next;

    pqp_pkg::ctrl_t                 cw;
    pqp_pkg::seq_stat_t             stat;
    logic [pqp_pkg::STEP_W-1:0]     step;
    logic signed [DATA_WIDTH-1:0]   target_value, measured_value;
    logic signed [pqp_pkg::DRIVE_W-1:0] drive;
    logic                           in_fire, out_free, out_load;

    assign target_value   = s_tdata[DATA_WIDTH-1:0];
    assign measured_value = s_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

    // An item is taken only in the idle step of the program.
    assign s_tready      = cw.in_rdy;
    assign in_fire       = s_tvalid && s_tready;
    assign out_free      = !m_tvalid_reg || m_tready;
    assign out_load      = cw.out_ld && out_free;
    assign stat.in_fire  = in_fire;
    assign stat.out_free = out_free;

    pqp_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cw    (cw),
        .step  (step)
    );

    pqp_datapath #(
        .DATA_WIDTH     (DATA_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cw             (cw),
        .in_fire        (in_fire),
        .target_value   (target_value),
        .measured_value (measured_value),
        .quad_gain      (quad_gain_reg),
        .prop_gain      (prop_gain_reg),
        .integ_gain     (integ_gain_reg),
        .deriv_gain     (deriv_gain_reg),
        .integ_limit    (integ_limit_reg),
        .drive_limit    (drive_limit_reg),
        .drive          (drive)
    );

    // Configuration writes; indexes beyond the register list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quad_gain_reg   <= '0;
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            deriv_gain_reg  <= '0;
            integ_limit_reg <= '0;
            drive_limit_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                pqp_pkg::REG_QUAD_GAIN:   quad_gain_reg   <= cfg_wdata;
                pqp_pkg::REG_PROP_GAIN:   prop_gain_reg   <= cfg_wdata;
                pqp_pkg::REG_INTEG_GAIN:  integ_gain_reg  <= cfg_wdata;
                pqp_pkg::REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_wdata;
                pqp_pkg::REG_INTEG_LIMIT: integ_limit_reg <= cfg_wdata;
                pqp_pkg::REG_DRIVE_LIMIT: drive_limit_reg <= cfg_wdata[pqp_pkg::DLIM_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // The output register is refilled only once its previous item has gone.
    always_comb
    begin
        m_tdata_next  = out_load ? drive : m_tdata_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        else
        begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------

    // A delivered drive always lies within the configured drive limit.
    a_drive_in_limit : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (($signed(m_tdata) <= $signed({1'b0, drive_limit_reg})) &&
                      ($signed(m_tdata) >= -$signed({1'b0, drive_limit_reg}))))
        else $error("drive item outside the drive limit");

    // Once an item is taken the block is busy with it in the next cycle.
    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("item accepted while the previous one is still at work");

    // The program must not leave its final step while the output is blocked.
    a_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
        (step == pqp_pkg::S_OUT && m_tvalid && !m_tready) |=> (step == pqp_pkg::S_OUT))
        else $error("sequencer left the output step during a stall");

    // A new result appears only from the output step.
    a_valid_from_out_step : assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> ($past(step) == pqp_pkg::S_OUT))
        else $error("result item raised outside the output step");

endmodule

// ===== rtl/pqp_mul.sv =====
// ============================================================================
// pqp_mul: shared unsigned multiplier
// One registered magnitude product per cycle.
// ============================================================================
module pqp_mul #(
    parameter int A_W = 24,
    parameter int B_W = 24
) (
    input  logic                 clk,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    output logic [A_W+B_W-1:0]   p
);

    logic [A_W+B_W-1:0] p_reg;
    logic [A_W+B_W-1:0] p_next;

    assign p_next = (A_W+B_W)'(a) * (A_W+B_W)'(b);
    assign p      = p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

endmodule

// ===== rtl/pqp_seq.sv =====
// ============================================================================
// pqp_seq: microcode sequencer
// Step counter, program table lookup and conditional jumps.
// ============================================================================
module pqp_seq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pqp_pkg::seq_stat_t          stat,
    output pqp_pkg::ctrl_t              cw,
    output logic [pqp_pkg::STEP_W-1:0]  step
);

    logic [pqp_pkg::STEP_W-1:0] step_reg;
    logic [pqp_pkg::STEP_W-1:0] step_next;

    assign cw   = pqp_pkg::ucode(step_reg);
    assign step = step_reg;

    always_comb
    begin
        case (cw.jmp)
            pqp_pkg::JC_NEXT: step_next = step_reg + 1'b1;
            pqp_pkg::JC_IN:   step_next = stat.in_fire ? step_reg + 1'b1 : step_reg;
            pqp_pkg::JC_OUT:  step_next = stat.out_free ? cw.target : step_reg;
            default:          step_next = cw.target;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= pqp_pkg::S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ===== rtl/pqp_datapath.sv =====
// ============================================================================
// pqp_datapath: arithmetic datapath of the controller
// Error, clamped integral, operand selection for the shared multiplier,
// magnitude accumulation, capping, scaling and the drive clamp.
// ============================================================================
module pqp_datapath #(
    parameter int DATA_WIDTH     = 16,
    parameter int GAIN_FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pqp_pkg::ctrl_t                       cw,
    input  logic                                 in_fire,
    input  logic signed [DATA_WIDTH-1:0]         target_value,
    input  logic signed [DATA_WIDTH-1:0]         measured_value,
    input  logic signed [pqp_pkg::GAIN_W-1:0]    quad_gain,
    input  logic signed [pqp_pkg::GAIN_W-1:0]    prop_gain,
    input  logic signed [pqp_pkg::GAIN_W-1:0]    integ_gain,
    input  logic signed [pqp_pkg::GAIN_W-1:0]    deriv_gain,
    input  logic [pqp_pkg::ILIM_W-1:0]           integ_limit,
    input  logic [pqp_pkg::DLIM_W-1:0]           drive_limit,
    output logic signed [pqp_pkg::DRIVE_W-1:0]   drive
);

    localparam int GW     = pqp_pkg::GAIN_W;
    localparam int ERR_W  = DATA_WIDTH + 1;
    localparam int DIFF_W = DATA_WIDTH + 2;
    localparam int MW     = (DATA_WIDTH + 1 > GW) ? DATA_WIDTH + 1 : GW;
    localparam int P_W    = 2 * MW;
    localparam int ES_W   = (DATA_WIDTH + 1 > pqp_pkg::ILIM_W) ? DATA_WIDTH + 3 : 26;
    localparam int MAG_W  = (GW + 2 * DATA_WIDTH > 63) ? GW + 2 * DATA_WIDTH : 63;
    localparam int SUM_W  = 66 - GAIN_FRAC_BITS;
    localparam logic [MAG_W-1:0] CAP = {{(MAG_W-1){1'b0}}, 1'b1} << 62;

    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [ERR_W-1:0]  last_err_reg, last_err_next;
    logic signed [ES_W-1:0]   esum_reg, esum_next;
    logic signed [DIFF_W-1:0] diff_reg, diff_next;
    logic [P_W-1:0]           e2_reg, e2_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic                     sign_reg, sign_next;
    logic signed [SUM_W-1:0]  term_reg, term_next;
    logic signed [SUM_W-1:0]  acc_reg, acc_next;

    logic [ERR_W-1:0]         abs_err;
    logic [ES_W-1:0]          abs_esum;
    logic [DIFF_W-1:0]        abs_diff;
    logic [GW-1:0]            mag_qg, mag_kp, mag_ki, mag_kd;
    logic [MW-1:0]            mul_a;
    logic [MW-1:0]            mul_b;
    logic [P_W-1:0]           prod;
    logic signed [ES_W-1:0]   esum_sum, ilim_s, nilim_s;
    logic [MAG_W-1:0]         capped;
    logic signed [MAG_W:0]    sterm, shifted;
    logic signed [SUM_W-1:0]  dlim_s, ndlim_s;

    pqp_mul #(
        .A_W (MW),
        .B_W (MW)
    ) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    always_comb
    begin
        // Magnitudes feeding the multiplier
        abs_err  = err_reg[ERR_W-1] ? ERR_W'(-err_reg) : ERR_W'(err_reg);
        abs_esum = esum_reg[ES_W-1] ? ES_W'(-esum_reg) : ES_W'(esum_reg);
        abs_diff = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
        mag_qg   = quad_gain[GW-1] ? GW'(-quad_gain) : GW'(quad_gain);
        mag_kp   = prop_gain[GW-1] ? GW'(-prop_gain) : GW'(prop_gain);
        mag_ki   = integ_gain[GW-1] ? GW'(-integ_gain) : GW'(integ_gain);
        mag_kd   = deriv_gain[GW-1] ? GW'(-deriv_gain) : GW'(deriv_gain);

        case (cw.a_sel)
            pqp_pkg::A_ERR: mul_a = MW'(abs_err);
            pqp_pkg::A_QG:  mul_a = MW'(mag_qg);
            pqp_pkg::A_KP:  mul_a = MW'(mag_kp);
            pqp_pkg::A_KI:  mul_a = MW'(mag_ki);
            pqp_pkg::A_KD:  mul_a = MW'(mag_kd);
            default:        mul_a = '0;
        endcase

        case (cw.b_sel)
            pqp_pkg::B_ERR:  mul_b = MW'(abs_err);
            pqp_pkg::B_E2LO: mul_b = e2_reg[MW-1:0];
            pqp_pkg::B_E2HI: mul_b = MW'(e2_reg[P_W-1:MW]);
            pqp_pkg::B_ESUM: mul_b = MW'(abs_esum);
            pqp_pkg::B_DIFF: mul_b = MW'(abs_diff);
            default:         mul_b = '0;
        endcase

        // Error capture on an accepted item
        err_next = in_fire ? ERR_W'(target_value) - ERR_W'(measured_value) : err_reg;

        // Integral update with symmetric clamp, derivative difference
        ilim_s   = $signed({{(ES_W-pqp_pkg::ILIM_W){1'b0}}, integ_limit});
        nilim_s  = -ilim_s;
        esum_sum = esum_reg + ES_W'(err_reg);
        esum_next     = esum_reg;
        diff_next     = diff_reg;
        last_err_next = last_err_reg;
        if (cw.upd_en)
        begin
            if (esum_sum > ilim_s)
            begin
                esum_next = ilim_s;
            end
            else if (esum_sum < nilim_s)
            begin
                esum_next = nilim_s;
            end
            else
            begin
                esum_next = esum_sum;
            end
            diff_next     = DIFF_W'(err_reg) - DIFF_W'(last_err_reg);
            last_err_next = err_reg;
        end

        e2_next = cw.e2_en ? prod : e2_reg;

        // Magnitude of the current term; the quadratic term arrives in two halves
        case (cw.mag_op)
            pqp_pkg::MAG_LOAD:   mag_next = MAG_W'(prod);
            pqp_pkg::MAG_ADD_HI: mag_next = mag_reg + (MAG_W'(prod) << MW);
            default:             mag_next = mag_reg;
        endcase

        sign_next = sign_reg;
        if (cw.mag_op == pqp_pkg::MAG_LOAD)
        begin
            case (cw.sign_sel)
                pqp_pkg::SG_P: sign_next = prop_gain[GW-1] ^ err_reg[ERR_W-1];
                pqp_pkg::SG_Q: sign_next = quad_gain[GW-1] ^ err_reg[ERR_W-1];
                pqp_pkg::SG_I: sign_next = integ_gain[GW-1] ^ esum_reg[ES_W-1];
                default:       sign_next = deriv_gain[GW-1] ^ diff_reg[DIFF_W-1];
            endcase
        end

        // Cap the magnitude, apply the sign, then floor-scale by the gain fraction
        capped    = (mag_reg > CAP) ? CAP : mag_reg;
        sterm     = sign_reg ? -$signed({1'b0, capped}) : $signed({1'b0, capped});
        shifted   = sterm >>> GAIN_FRAC_BITS;
        term_next = cw.term_en ? shifted[SUM_W-1:0] : term_reg;

        case (cw.acc_op)
            pqp_pkg::ACC_CLEAR: acc_next = '0;
            pqp_pkg::ACC_ADD:   acc_next = acc_reg + term_reg;
            default:            acc_next = acc_reg;
        endcase

        // Drive clamp
        dlim_s  = $signed({{(SUM_W-pqp_pkg::DLIM_W){1'b0}}, drive_limit});
        ndlim_s = -dlim_s;
        if (acc_reg > dlim_s)
        begin
            drive = dlim_s[pqp_pkg::DRIVE_W-1:0];
        end
        else if (acc_reg < ndlim_s)
        begin
            drive = ndlim_s[pqp_pkg::DRIVE_W-1:0];
        end
        else
        begin
            drive = acc_reg[pqp_pkg::DRIVE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            esum_reg     <= '0;
            last_err_reg <= '0;
        end
        else
        begin
            esum_reg     <= esum_next;
            last_err_reg <= last_err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg  <= err_next;
        diff_reg <= diff_next;
        e2_reg   <= e2_next;
        mag_reg  <= mag_next;
        sign_reg <= sign_next;
        term_reg <= term_next;
        acc_reg  <= acc_next;
    end

endmodule

// ===== tb/tb_positional_pid_quadratic_p.sv =====
// ----------------------------------------------------------------------------
// tb_positional_pid_quadratic_p: self-checking bench for the quadratic-P PID
// Drives setpoint/measurement items into the controller under random source
// and sink idling, programs a series of gain and limit settings between
// phases, and compares every drive item with an in-bench fixed-point model.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Holds the controller's register set and loop state as the block should see
// them, and the queue of drive values still owed by the block.
class drive_scoreboard;
    localparam int FRAC_BITS = 16;

    logic signed [23:0] quad_gain   = '0;
    logic signed [23:0] prop_gain   = '0;
    logic signed [23:0] integ_gain  = '0;
    logic signed [23:0] deriv_gain  = '0;
    logic        [23:0] integ_limit = '0;
    logic        [14:0] drive_limit = '0;

    longint integ_sum     = 0;
    longint earlier_error = 0;

    logic [15:0] owed_drive[$];
    int          n_checked = 0;
    int          n_errors  = 0;

    function void write_reg(input logic [2:0] idx, input logic [23:0] value);
        case (idx)
            pqp_pkg::REG_QUAD_GAIN:   quad_gain   = value;
            pqp_pkg::REG_PROP_GAIN:   prop_gain   = value;
            pqp_pkg::REG_INTEG_GAIN:  integ_gain  = value;
            pqp_pkg::REG_DERIV_GAIN:  deriv_gain  = value;
            pqp_pkg::REG_INTEG_LIMIT: integ_limit = value;
            pqp_pkg::REG_DRIVE_LIMIT: drive_limit = value[14:0];
            default: ;
        endcase
    endfunction

    // Floor of gain*operand / 2^16. With 24-bit gains and 16-bit samples
    // the exact product stays far below 2^62, so no saturation is needed.
    function longint scaled(input longint gain, input longint operand);
        return (gain * operand) >>> FRAC_BITS;
    endfunction

    function void note_sample(input logic signed [15:0] target,
                              input logic signed [15:0] measured);
        longint err;
        longint abs_err;
        longint ilim;
        longint dlim;
        longint drive;
        err     = longint'(target) - longint'(measured);
        abs_err = (err < 0) ? -err : err;
        ilim    = longint'(integ_limit);
        dlim    = longint'(drive_limit);

        integ_sum = integ_sum + err;
        if (integ_sum > ilim)
            integ_sum = ilim;
        else if (integ_sum < -ilim)
            integ_sum = -ilim;

        drive = scaled(longint'(quad_gain), err * abs_err)
              + scaled(longint'(prop_gain), err)
              + scaled(longint'(integ_gain), integ_sum)
              + scaled(longint'(deriv_gain), err - earlier_error);
        earlier_error = err;

        if (drive > dlim)
            drive = dlim;
        if (drive < -dlim)
            drive = -dlim;
        owed_drive.push_back(drive[15:0]);
    endfunction

    function void check_drive(input logic [15:0] got);
        logic [15:0] want;
        if (owed_drive.size() == 0)
        begin
            $error("drive: no item expected, got %0d", $signed(got));
            n_errors++;
        end
        else
        begin
            want = owed_drive.pop_front();
            n_checked++;
            if (got !== want)
            begin
                $error("drive: expected %0d, got %0d", $signed(want), $signed(got));
                n_errors++;
            end
        end
    endfunction

    function int pending();
        return owed_drive.size();
    endfunction
endclass

module tb_positional_pid_quadratic_p;

    localparam int MAX_WAIT = 12;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_wdata = '0;

    // When set, the source or the sink stops idling for a while so that the
    // block also sees back-to-back traffic.
    bit tx_steady = 1'b0;
    bit rx_steady = 1'b0;

    int n_items    = 0;
    int n_settings = 0;

    drive_scoreboard sb = new();

    positional_pid_quadratic_p u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        // s_tdata, from bit 0: target_value, measured_value
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        // m_tdata, from bit 0: drive
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Both handshakes are sampled at the clock edge, before any of this edge's
    // nonblocking updates land. The result is checked before the new input is
    // noted, so a stray result can never be matched against its own item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_drive(m_tdata);
            if (s_tvalid && s_tready)
            begin
                sb.note_sample(s_tdata[15:0], s_tdata[31:16]);
                n_items++;
            end
        end
    end

    // The sink draws a stall before each item and now and then switches to a
    // stretch of always-ready behaviour.
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Register writes go out on consecutive edges; the caller lowers the
    // write enable once the whole set has gone.
    task automatic set_reg(input logic [2:0] idx, input logic [23:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        sb.write_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic program_loop(input logic [23:0] qg, input logic [23:0] kp,
                                input logic [23:0] ki, input logic [23:0] kd,
                                input logic [23:0] ilim, input logic [23:0] dlim);
        set_reg(pqp_pkg::REG_QUAD_GAIN, qg);
        set_reg(pqp_pkg::REG_PROP_GAIN, kp);
        set_reg(pqp_pkg::REG_INTEG_GAIN, ki);
        set_reg(pqp_pkg::REG_DERIV_GAIN, kd);
        set_reg(pqp_pkg::REG_INTEG_LIMIT, ilim);
        set_reg(pqp_pkg::REG_DRIVE_LIMIT, dlim);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Offer one item after a random gap and hold it until it is taken.
    // tvalid stays high between items when the gap is zero.
    task automatic send_sample(input logic [15:0] target, input logic [15:0] measured);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {measured, target};
        do @(posedge clk); while (!s_tready);
    endtask

    // Drop tvalid and hold off until every owed drive item has come back.
    // The first edge also lets the monitor note the item just taken.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [23:0] pick_gain(input int spread);
        logic [23:0] g;
        case ($urandom_range(0, 9))
            0: g = 24'h800000;
            1: g = 24'h7FFFFF;
            2: g = '0;
            3: g = 24'($urandom);
            default:
            begin
                g = 24'($urandom_range(0, 1 << spread));
                if ($urandom_range(0, 1))
                    g = -g;
            end
        endcase
        return g;
    endfunction

    function automatic logic [23:0] pick_integ_limit();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 24'hFFFFFF;
            2: return 24'($urandom);
            3: return 24'($urandom_range(0, 100000));
            default: return 24'($urandom_range(0, 2000));
        endcase
    endfunction

    // The upper nine bits of the drive limit write are ignored by the block,
    // so they are often filled with junk.
    function automatic logic [23:0] pick_drive_limit();
        logic [23:0] d;
        case ($urandom_range(0, 4))
            0: d = '0;
            1: d = 24'h007FFF;
            default: d = 24'($urandom_range(0, 32767));
        endcase
        if ($urandom_range(0, 1))
            d[23:15] = 9'($urandom);
        return d;
    endfunction

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d drive items outstanding", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        logic [15:0] tgt;
        logic [15:0] meas;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With every register still at its reset value the drive must be
        // zero and the integral must not move.
        send_sample(16'sd1000, -16'sd1000);
        send_sample(-16'sd32768, 16'sd32767);
        drain_results();

        // Moderate gains: unit P, a small quadratic and integral gain and a
        // half-unit derivative, with room in both limits.
        program_loop(24'd8, 24'd65536, 24'd4096, 24'd32768, 24'd1000, 24'd32767);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd100, -16'sd100);
        send_sample(-16'sd100, 16'sd100);
        send_sample(16'sd5, 16'sd5);
        send_sample(16'sd1, 16'sd0);
        send_sample(16'sd0, 16'sd1);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(16'sd1234, -16'sd4321);
        drain_results();

        // Full-scale gains of alternating sign and the widest limits; the
        // drive limit write also carries set bits above its fifteen.
        program_loop(24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF,
                     24'hFFFFFF, 24'hFFFFFF);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd3, 16'sd7);
        send_sample(16'sd7, 16'sd3);
        send_sample(16'sd0, 16'sd0);
        drain_results();

        // Zero limits pin the integral and force the drive to zero.
        program_loop(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'd0, 24'd0);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd2000, 16'sd50);
        send_sample(16'sd9, 16'sd9);
        drain_results();

        // Random phases, each under a fresh register setting. Most items keep
        // the error small so the integral and clamps act over long runs;
        // the rest use the full sample range.
        for (int phase = 0; phase < 14; phase++)
        begin
            program_loop(pick_gain(6), pick_gain(17), pick_gain(14), pick_gain(17),
                         pick_integ_limit(), pick_drive_limit());
            for (int n = 0; n < 100; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    tx_steady = !tx_steady;
                if ($urandom_range(0, 149) == 0)
                    drain_results();
                meas = 16'($urandom);
                case ($urandom_range(0, 4))
                    0: tgt = 16'($urandom);
                    1: tgt = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
                    default: tgt = meas + 16'($urandom_range(0, 400)) - 16'd200;
                endcase
                send_sample(tgt, meas);
            end
            drain_results();
        end

        // Let any late or stray result show up before judging the run.
        repeat (30) @(posedge clk);
        $display("Covered %0d items and %0d drive results over %0d register settings,",
                 n_items, sb.n_checked, n_settings);
        $display("including zero and full-scale gains and limits, with random idling.");
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/pqp_pkg.sv
rtl/pqp_mul.sv
rtl/pqp_seq.sv
rtl/pqp_datapath.sv
rtl/positional_pid_quadratic_p.sv
tb/tb_positional_pid_quadratic_p.sv
